// ===== src/ordered_set_store_macros.svh =====
// Assertion macros for the ordered set store checker.
`ifndef ORDERED_SET_STORE_MACROS_SVH
`define ORDERED_SET_STORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered_set_store check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered_set_store check failed");

`endif

// ===== src/oss_pkg.sv =====
// -----------------------------------------------------------------------------
// oss_pkg
// Shared constants and types for the ordered set store and its cells.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oss_pkg;

  localparam int OSS_CAPACITY = 16;
  localparam int OSS_ELEM_W   = 32;
  localparam int OSS_CNT_W    = $clog2(OSS_CAPACITY + 1);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // Broadcast control, same for every cell
  typedef struct packed {
    logic                  add_en;
    logic                  remove_en;
    logic                  clear_en;
    logic [OSS_ELEM_W-1:0] elem;
  } cell_ctrl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic                  valid;
    logic [OSS_ELEM_W-1:0] data;
  } cell_entry_t;

endpackage

// ===== src/oss_cell.sv =====
// -----------------------------------------------------------------------------
// oss_cell
// One entry of the compacted set: compares against the broadcast element,
// takes the right neighbor's entry on a remove, loads on an append.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oss_cell import oss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  logic        left_valid_i,
  input  logic        hit_chain_i,
  input  cell_entry_t right_i,
  output logic        hit_chain_o,
  output cell_entry_t entry_o,
  output cell_entry_t entry_next_o
);

  logic                  valid_q, valid_d;
  logic [OSS_ELEM_W-1:0] data_q, data_d;
  logic                  hit;

  assign hit         = valid_q && (data_q == ctrl_i.elem);
  // Set once a match has been seen at or left of this cell
  assign hit_chain_o = hit_chain_i | hit;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.clear_en) begin
      valid_d = 1'b0;
    end else if (ctrl_i.remove_en && hit_chain_o) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
    end else if (ctrl_i.add_en && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      data_d  = ctrl_i.elem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign entry_o.valid      = valid_q;
  assign entry_o.data       = data_q;
  assign entry_next_o.valid = valid_d;
  assign entry_next_o.data  = data_d;

endmodule

// ===== src/ordered_set_store.sv =====
// Ordered set store: a row of OSS_CAPACITY cells holding a compacted, insertion-ordered set.
// The result of an item is registered and shows on the output in the cycle after it is accepted.
// Throughput: one item per cycle while input is not stalled; a match ripples through the cell row in that cycle.
// Input is stalled only while an unread result is itself stalled.
// Reset (async, active low) empties the set and drops any pending result; no clearing pass.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_set_store import oss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        was_present_o,
  output logic [4:0]  element_count_o,
  output logic        is_empty_o,
  output logic [31:0] oldest_element_o,
  output logic        status_o
);

  logic                 accept;
  logic                 present, full;
  kind_e                kind;
  cell_ctrl_t           ctrl;
  logic [OSS_CNT_W-1:0] count_q, count_d;

  cell_entry_t entry_w      [OSS_CAPACITY];
  cell_entry_t entry_next_w [OSS_CAPACITY];
  cell_entry_t right_w      [OSS_CAPACITY];
  logic        left_valid_w [OSS_CAPACITY];
  logic [OSS_CAPACITY:0] chain_w;

  logic        out_valid_q;
  logic        was_present_q, is_empty_q, status_q;
  logic [4:0]  count_out_q;
  logic [31:0] oldest_q, oldest_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign kind       = kind_e'(kind_i);

  assign present = chain_w[OSS_CAPACITY];
  assign full    = entry_w[OSS_CAPACITY-1].valid;

  assign ctrl.elem      = element_i[OSS_ELEM_W-1:0];
  assign ctrl.add_en    = accept && (kind == KIND_ADD) && !present && !full;
  assign ctrl.remove_en = accept && (kind == KIND_REMOVE) && present;
  assign ctrl.clear_en  = accept && (kind == KIND_CLEAR);

  assign chain_w[0] = 1'b0;

  for (genvar i = 0; i < OSS_CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_valid_w[i] = 1'b1;
    end else begin : g_rest
      assign left_valid_w[i] = entry_w[i-1].valid;
    end
    if (i == OSS_CAPACITY - 1) begin : g_last
      assign right_w[i].valid = 1'b0;
      assign right_w[i].data  = '0;
    end else begin : g_inner
      assign right_w[i] = entry_w[i+1];
    end

    oss_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_valid_i (left_valid_w[i]),
      .hit_chain_i  (chain_w[i]),
      .right_i      (right_w[i]),
      .hit_chain_o  (chain_w[i+1]),
      .entry_o      (entry_w[i]),
      .entry_next_o (entry_next_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.clear_en) begin
      count_d = '0;
    end else if (ctrl.add_en) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.remove_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    oldest_d = '0;
    if (entry_next_w[0].valid) begin
      oldest_d = 32'(entry_next_w[0].data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      was_present_q <= present;
      count_out_q   <= 5'(count_d);
      is_empty_q    <= (count_d == '0);
      oldest_q      <= oldest_d;
      status_q      <= (kind == KIND_ADD) && !present && full;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign was_present_o    = was_present_q;
  assign element_count_o  = count_out_q;
  assign is_empty_o       = is_empty_q;
  assign oldest_element_o = oldest_q;
  assign status_o         = status_q;

endmodule

// ===== src/oss_checker.sv =====
// -----------------------------------------------------------------------------
// oss_checker
// Port-level checks on the ordered set store results, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_set_store_macros.svh"

module oss_checker import oss_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        was_present_o,
  input logic [4:0]  element_count_o,
  input logic        is_empty_o,
  input logic [31:0] oldest_element_o,
  input logic        status_o
);

  `OSS_ASSERT_NOW(a_empty_matches_count, out_valid_o, is_empty_o == (element_count_o == 5'd0))
  `OSS_ASSERT_NOW(a_empty_oldest_zero, out_valid_o && is_empty_o, oldest_element_o == 32'd0)
  `OSS_ASSERT_NOW(a_full_drop_absent, out_valid_o && status_o,
                  !was_present_o && (int'(element_count_o) == OSS_CAPACITY))
  `OSS_ASSERT_NOW(a_count_bound, out_valid_o, int'(element_count_o) <= OSS_CAPACITY)
  `OSS_ASSERT_NXT(a_stalled_result_holds, out_valid_o && out_stall_i,
                  out_valid_o && $stable(element_count_o) && $stable(oldest_element_o))

endmodule

bind ordered_set_store oss_checker u_oss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .was_present_o    (was_present_o),
  .element_count_o  (element_count_o),
  .is_empty_o       (is_empty_o),
  .oldest_element_o (oldest_element_o),
  .status_o         (status_o)
);
